[src/orovl_pkg.sv]
// Shared constants and types for the oriented rectangle overlap test.
package orovl_pkg;

    // Coordinate width of every input field (signed Q16.16)
    localparam int CW       = 32;
    localparam int NFIELD   = 12;
    localparam int IN_W     = NFIELD * CW;
    localparam int OUT_W    = 8;
    localparam int NEDGE    = 4;
    localparam int NPAIR    = 10;

    // Derived arithmetic widths
    localparam int DW       = CW + 1;       // center difference
    localparam int PEE_W    = 2 * CW;       // edge x edge product
    localparam int PED_W    = CW + DW;      // diff x edge product
    localparam int DOT_W    = PEE_W;        // |edge . edge| magnitude
    localparam int GAP_W    = PED_W;        // |diff . edge| magnitude
    localparam int SUM_W    = DOT_W + 2;    // sum of four magnitudes, also 2*gap

    // Field slots inside s_tdata
    localparam int F_LCX    = 8;
    localparam int F_LCY    = 9;
    localparam int F_RCX    = 10;
    localparam int F_RCY    = 11;

    typedef logic signed [CW-1:0]    coord_t;
    typedef logic signed [DW-1:0]    diff_t;
    typedef logic signed [PEE_W-1:0] pee_t;
    typedef logic signed [PED_W-1:0] ped_t;
    typedef logic [DOT_W-1:0]        dot_t;
    typedef logic [GAP_W-1:0]        gap_t;
    typedef logic [SUM_W-1:0]        sum_t;
    typedef logic [3:0]              pidx_t;

    // Unique edge pairs; dot products are symmetric, so ten cover all sixteen
    localparam logic [1:0] PAIR_A [NPAIR] = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1,
                                              2'd1, 2'd1, 2'd2, 2'd2, 2'd3};
    localparam logic [1:0] PAIR_B [NPAIR] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1,
                                              2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

    // Pair slot for axis i and edge k
    localparam pidx_t PAIR_IDX [NEDGE][NEDGE] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3},
        '{4'd1, 4'd4, 4'd5, 4'd6},
        '{4'd2, 4'd5, 4'd7, 4'd8},
        '{4'd3, 4'd6, 4'd8, 4'd9}
    };

endpackage

[src/oriented_rect_overlap_test_top.sv]
// Five-stage pipelined 2D separating-axis test on two oriented rectangles.
//
//  channel  | dir | tdata (low bit up)                          | tuser | tlast
//  s_       | in  | 12 x 32b: lea.x lea.y leb.x leb.y rea.x rea.y |  -    |  -
//           |     |   reb.x reb.y lc.x lc.y rc.x rc.y              |       |
//  m_       | out | [0] overlap, [7:1] zero                        |  -    |  -
//
// One item per cycle unless m_ stalls; m_tvalid rises once the item is in the output register.
// Stages: input register, 28 multipliers, dot sums and abs, extent sums,
// compare and reduce into the output register.
// Each stage holds a valid bit and loads whenever it is empty or the stage
// after it moves, so bubbles close up and a stall at m_ loses nothing.
// aresetn (synchronous) clears only the valid bits.
module oriented_rect_overlap_test_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // lea.x, lea.y, leb.x, leb.y, rea.x, rea.y, reb.x, reb.y, lc.x, lc.y, rc.x, rc.y
    input  logic [orovl_pkg::IN_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // overlap, then zero padding
    output logic [orovl_pkg::OUT_W-1:0] m_tdata
);

    localparam int NE = orovl_pkg::NEDGE;
    localparam int NP = orovl_pkg::NPAIR;
    localparam int CW = orovl_pkg::CW;

    // Stage valid bits and load enables
    logic [4:0] vld_reg;
    logic [4:0] en;

    // Stage 1: edges and center difference
    orovl_pkg::coord_t ex_reg [NE];
    orovl_pkg::coord_t ey_reg [NE];
    orovl_pkg::diff_t  dx_reg, dy_reg;

    // Stage 2: products
    orovl_pkg::pee_t pex_reg [NP];
    orovl_pkg::pee_t pey_reg [NP];
    orovl_pkg::ped_t pdx_reg [NE];
    orovl_pkg::ped_t pdy_reg [NE];

    // Stage 3: absolute dot products
    orovl_pkg::dot_t dot_reg [NP];
    orovl_pkg::gap_t gap_reg [NE];

    // Stage 4: extent and doubled gap per axis
    orovl_pkg::sum_t ext_reg  [NE];
    orovl_pkg::sum_t gap2_reg [NE];

    // Stage 5: result
    logic overlap_reg;
    logic overlap_next;

    // Enable chain: a stage loads when empty or when its successor loads
    always_comb begin
        en[4] = !vld_reg[4] || m_tready;
        for (int s = 3; s >= 0; s--) begin
            en[s] = !vld_reg[s] || en[s+1];
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[4];
    assign m_tdata  = {{(orovl_pkg::OUT_W-1){1'b0}}, overlap_reg};

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) vld_reg[0] <= s_tvalid;
            for (int s = 1; s < 5; s++) begin
                if (en[s]) vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // Stage 1: unpack fields and take the center difference
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int k = 0; k < NE; k++) begin
                ex_reg[k] <= s_tdata[(2*k)*CW +: CW];
                ey_reg[k] <= s_tdata[(2*k+1)*CW +: CW];
            end
            dx_reg <= orovl_pkg::diff_t'($signed(s_tdata[orovl_pkg::F_LCX*CW +: CW]))
                    - orovl_pkg::diff_t'($signed(s_tdata[orovl_pkg::F_RCX*CW +: CW]));
            dy_reg <= orovl_pkg::diff_t'($signed(s_tdata[orovl_pkg::F_LCY*CW +: CW]))
                    - orovl_pkg::diff_t'($signed(s_tdata[orovl_pkg::F_RCY*CW +: CW]));
        end
    end

    // Stage 2: component products
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int p = 0; p < NP; p++) begin
                pex_reg[p] <= orovl_pkg::pee_t'(ex_reg[orovl_pkg::PAIR_A[p]])
                            * orovl_pkg::pee_t'(ex_reg[orovl_pkg::PAIR_B[p]]);
                pey_reg[p] <= orovl_pkg::pee_t'(ey_reg[orovl_pkg::PAIR_A[p]])
                            * orovl_pkg::pee_t'(ey_reg[orovl_pkg::PAIR_B[p]]);
            end
            for (int i = 0; i < NE; i++) begin
                pdx_reg[i] <= orovl_pkg::ped_t'(dx_reg) * orovl_pkg::ped_t'(ex_reg[i]);
                pdy_reg[i] <= orovl_pkg::ped_t'(dy_reg) * orovl_pkg::ped_t'(ey_reg[i]);
            end
        end
    end

    // Stage 3: dot sums and magnitudes
    always_ff @(posedge aclk) begin
        logic signed [orovl_pkg::PEE_W:0] se;
        logic signed [orovl_pkg::PED_W:0] sd;
        if (en[2]) begin
            for (int p = 0; p < NP; p++) begin
                se = (orovl_pkg::PEE_W+1)'(pex_reg[p]) + (orovl_pkg::PEE_W+1)'(pey_reg[p]);
                dot_reg[p] <= orovl_pkg::DOT_W'(se[orovl_pkg::PEE_W] ? -se : se);
            end
            for (int i = 0; i < NE; i++) begin
                sd = (orovl_pkg::PED_W+1)'(pdx_reg[i]) + (orovl_pkg::PED_W+1)'(pdy_reg[i]);
                gap_reg[i] <= orovl_pkg::GAP_W'(sd[orovl_pkg::PED_W] ? -sd : sd);
            end
        end
    end

    // Stage 4: half-extent sum (times two) and doubled gap per axis
    always_ff @(posedge aclk) begin
        if (en[3]) begin
            for (int i = 0; i < NE; i++) begin
                ext_reg[i] <= orovl_pkg::sum_t'(dot_reg[orovl_pkg::PAIR_IDX[i][0]])
                            + orovl_pkg::sum_t'(dot_reg[orovl_pkg::PAIR_IDX[i][1]])
                            + orovl_pkg::sum_t'(dot_reg[orovl_pkg::PAIR_IDX[i][2]])
                            + orovl_pkg::sum_t'(dot_reg[orovl_pkg::PAIR_IDX[i][3]]);
                gap2_reg[i] <= {gap_reg[i], 1'b0};
            end
        end
    end

    // Stage 5: an axis separates when the extent falls short of the gap
    always_comb begin
        overlap_next = 1'b1;
        for (int i = 0; i < NE; i++) begin
            if (ext_reg[i] < gap2_reg[i]) overlap_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            overlap_reg <= overlap_next;
        end
    end

endmodule

[src/orovl_checker.sv]
// Port-level checks for the overlap test, bound to the top level.
module orovl_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [orovl_pkg::OUT_W-1:0] m_tdata
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

    // A held result does not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Padding bits stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[orovl_pkg::OUT_W-1:1] == '0)
        else $error("nonzero padding in m_tdata");

    // Input side is never blocked while the output moves or is empty
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tready || !m_tvalid) |-> s_tready)
        else $error("s_tready low with output free");

endmodule

bind oriented_rect_overlap_test_top orovl_checker u_orovl_checker (.*);
